[sv/tcce_pkg.sv]
`default_nettype none
package tcce_pkg;

  localparam int SCREEN_W    = 480;
  localparam int SCREEN_H    = 320;
  localparam int EDGE_MARGIN = 4;

  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SETBG = 2'd2;

  localparam logic [1:0] FONT_4X6  = 2'd0;
  localparam logic [1:0] FONT_8X8  = 2'd1;
  localparam logic [1:0] FONT_8X16 = 2'd2;
  localparam logic [1:0] FONT_NONE = 2'd3;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [6:0] GLYPH_SUBST = 7'd63;

  localparam logic [23:0] FG_RESET_RGB = 24'hE8E8E8;
  localparam logic [23:0] BG_RESET_RGB = 24'h202428;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_FONT   = 2'd1,
    CFG_FG     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_ERASE  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_FILL   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_PRINT,
    K_CR,
    K_LF,
    K_BS,
    K_TAB,
    K_CLEAR,
    K_SETBG
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  glyph;
    logic [15:0] color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    op_t         op;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [6:0]  glyph;
    logic [15:0] fore;
    logic [15:0] back;
    logic [3:0]  cell_w;
    logic [4:0]  cell_h;
    logic        last;
  } res_t;

  function automatic logic [15:0] to565s(input logic [23:0] rgb);
    logic [15:0] v;
    v = {rgb[23:19], rgb[15:10], rgb[7:3]};
    return {v[7:0], v[15:8]};
  endfunction

  localparam logic [15:0] BG_RESET = to565s(BG_RESET_RGB);

endpackage
`default_nettype wire

[sv/tcce_front.sv]
`default_nettype none
module tcce_front
  import tcce_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  char_code,
  input  wire logic [23:0] color_rgb,
  input  wire logic        enable,
  input  wire fifo_stat_t  stat,
  output logic             push,
  output cmd_t             cmd
);

  logic keep;

  always_comb begin
    keep      = 1'b1;
    cmd.kind  = K_PRINT;
    cmd.glyph = char_code[7] ? GLYPH_SUBST : char_code[6:0];
    cmd.color = to565s(color_rgb);
    case (action)
      ACT_CHAR: begin
        case (char_code)
          CH_CR:   cmd.kind = K_CR;
          CH_LF:   cmd.kind = K_LF;
          CH_BS:   cmd.kind = K_BS;
          CH_TAB:  cmd.kind = K_TAB;
          default: cmd.kind = K_PRINT;
        endcase
      end
      ACT_CLEAR: cmd.kind = K_CLEAR;
      ACT_SETBG: cmd.kind = K_SETBG;
      default:   keep = 1'b0;
    endcase
  end

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready && enable && keep;

endmodule
`default_nettype wire

[sv/tcce_fifo.sv]
`default_nettype none
module tcce_fifo
  import tcce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t cmd_in,
  input  wire logic pop,
  output cmd_t      cmd_out,
  output fifo_stat_t stat
);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign cmd_out    = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

[sv/tcce_back.sv]
`default_nettype none
module tcce_back
  import tcce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire fifo_stat_t  stat,
  output logic             pop,
  input  wire logic [1:0]  font_select,
  input  wire logic [23:0] fg_rgb,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             res
);

  localparam logic [9:0] MARGIN = 10'(EDGE_MARGIN);

  logic [9:0]  cx;
  logic [8:0]  cy;
  logic [15:0] bg;
  logic        hold_valid;
  res_t        hold;

  logic [3:0]  w;
  logic [4:0]  h;
  logic [15:0] fg565;
  logic [9:0]  y_lf;
  logic        scroll;
  logic [8:0]  cy_lf;
  logic        wrap;
  logic [9:0]  cx_eff;
  logic [8:0]  cy_eff;
  logic [9:0]  cx_bs;
  logic [6:0]  tab;
  logic [10:0] d;
  logic [11:0] nx;
  logic        tab_wrap;
  logic [1:0]  n;
  res_t        r0;
  res_t        r1;
  logic [9:0]  cx_next;
  logic [8:0]  cy_next;
  logic [15:0] bg_next;
  logic        load;

  function automatic res_t make_res(input op_t o, input logic [8:0] x, input logic [8:0] y,
                                    input logic [6:0] g, input logic [15:0] f,
                                    input logic [15:0] b, input logic [3:0] cw,
                                    input logic [4:0] ch, input logic lst);
    res_t r;
    r.op     = o;
    r.pos_x  = x;
    r.pos_y  = y;
    r.glyph  = g;
    r.fore   = f;
    r.back   = b;
    r.cell_w = cw;
    r.cell_h = ch;
    r.last   = lst;
    return r;
  endfunction

  always_comb begin
    w      = (font_select == FONT_4X6) ? 4'd4 : 4'd8;
    h      = (font_select == FONT_4X6) ? 5'd6 : ((font_select == FONT_8X16) ? 5'd16 : 5'd8);
    fg565  = to565s(fg_rgb);

    y_lf   = {1'b0, cy} + 10'(h);
    scroll = ({1'b0, y_lf} + 11'(h)) > 11'(SCREEN_H);
    cy_lf  = scroll ? cy : y_lf[8:0];

    wrap   = ({1'b0, cx} + 11'(w)) > 11'(SCREEN_W - EDGE_MARGIN);
    cx_eff = wrap ? MARGIN : cx;
    cy_eff = wrap ? cy_lf : cy;

    cx_bs  = (cx >= 10'(w)) ? (cx - 10'(w)) : '0;

    tab      = {w, 3'b000};
    d        = {1'b0, cx} - 11'(EDGE_MARGIN) + 11'(tab);
    nx       = 12'(EDGE_MARGIN) + {1'b0, d & ~(11'(tab) - 11'd1)};
    tab_wrap = (nx + 12'(w)) > 12'(SCREEN_W);
  end

  always_comb begin
    n       = 2'd0;
    r0      = make_res(OP_SCROLL, '0, '0, '0, '0, bg, w, h, 1'b1);
    r1      = make_res(OP_DRAW, cx_eff[8:0], cy_eff, cmd.glyph, fg565, bg, w, h, 1'b1);
    cx_next = cx;
    cy_next = cy;
    bg_next = bg;
    case (cmd.kind)
      K_CLEAR: begin
        bg_next = cmd.color;
        n       = 2'd1;
        r0      = make_res(OP_FILL, '0, '0, '0, '0, cmd.color, w, h, 1'b1);
        cx_next = MARGIN;
        cy_next = MARGIN[8:0];
      end
      K_SETBG: begin
        bg_next = cmd.color;
      end
      K_CR: begin
        cx_next = MARGIN;
      end
      K_LF: begin
        cx_next = MARGIN;
        cy_next = cy_lf;
        n       = scroll ? 2'd1 : 2'd0;
      end
      K_BS: begin
        if (cx > MARGIN) begin
          cx_next = cx_bs;
          n       = 2'd1;
          r0      = make_res(OP_ERASE, cx_bs[8:0], cy, '0, '0, bg, w, h, 1'b1);
        end
      end
      K_TAB: begin
        if (tab_wrap) begin
          cx_next = MARGIN;
          cy_next = cy_lf;
          n       = scroll ? 2'd1 : 2'd0;
        end else begin
          cx_next = nx[9:0];
        end
      end
      K_PRINT: begin
        cx_next = cx_eff + 10'(w);
        cy_next = cy_eff;
        if (wrap && scroll) begin
          n       = 2'd2;
          r0.last = 1'b0;
        end else begin
          n  = 2'd1;
          r0 = r1;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
  end

  assign load = !out_valid || out_ready;
  assign pop  = load && !hold_valid && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      cx         <= MARGIN;
      cy         <= MARGIN[8:0];
      bg         <= BG_RESET;
    end else if (load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (pop) begin
        out_valid  <= (n != 2'd0);
        hold_valid <= (n == 2'd2);
        cx         <= cx_next;
        cy         <= cy_next;
        bg         <= bg_next;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        res <= hold;
      end else if (pop) begin
        res  <= r0;
        hold <= r1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/text_console_cursor_engine.sv]
// Channel  Signals                                    Moves
// in       in_valid/in_ready, action, char_code,      one console request
//          color_rgb
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   one register write
// out      out_valid/out_ready, op .. last            one drawing command
//
// A request enters a four-entry queue in the cycle it is accepted; in_ready drops only
// when the queue is full. The back end makes at most one command per request, two for a
// character that wraps and scrolls; the first is loaded into the output register as its
// request is popped, a second waits in a hold register, popping nothing, until the first
// is taken. Reset sets the pen to the margin, the background to 0x2521, the registers to
// enable 1, 8x8 font, foreground 0xE8E8E8, and empties the queue.
// A stalled output holds the back end; the queue keeps taking requests until full.
`default_nettype none
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  char_code,
  input  wire logic [23:0] color_rgb,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       op,
  output logic [8:0]       pos_x,
  output logic [8:0]       pos_y,
  output logic [6:0]       glyph,
  output logic [15:0]      fore565,
  output logic [15:0]      back565,
  output logic [3:0]       cell_w,
  output logic [4:0]       cell_h,
  output logic             last
);

  logic        enable;
  logic [1:0]  font_select;
  logic [23:0] fg_rgb;

  logic        push;
  logic        pop;
  cmd_t        cmd_in;
  cmd_t        cmd_out;
  fifo_stat_t  stat;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b1;
      font_select <= FONT_8X8;
      fg_rgb      <= FG_RESET_RGB;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable <= cfg_data[0];
        CFG_FONT: begin
          if (cfg_data[1:0] != FONT_NONE) begin
            font_select <= cfg_data[1:0];
          end
        end
        CFG_FG:     fg_rgb <= cfg_data;
        default:    enable <= enable;
      endcase
    end
  end

  tcce_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .char_code (char_code),
    .color_rgb (color_rgb),
    .enable    (enable),
    .stat      (stat),
    .push      (push),
    .cmd       (cmd_in)
  );

  tcce_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_out),
    .stat    (stat)
  );

  tcce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_out),
    .stat        (stat),
    .pop         (pop),
    .font_select (font_select),
    .fg_rgb      (fg_rgb),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign op      = res.op;
  assign pos_x   = res.pos_x;
  assign pos_y   = res.pos_y;
  assign glyph   = res.glyph;
  assign fore565 = res.fore;
  assign back565 = res.back;
  assign cell_w  = res.cell_w;
  assign cell_h  = res.cell_h;
  assign last    = res.last;

`ifndef SYNTHESIS
  a_scroll_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && op == OP_SCROLL |-> pos_x == 9'd0 && pos_y == 9'd0)
    else $error("scroll command carries a position");

  a_fore_draw_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && op != OP_DRAW |-> fore565 == 16'd0 && glyph == 7'd0)
    else $error("non-draw command carries glyph or foreground");

  a_final_cmds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (op == OP_DRAW || op == OP_FILL || op == OP_ERASE) |-> last)
    else $error("draw, erase or fill command not marked last");

  a_cell_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_w == 4'd4 |-> cell_h == 5'd6)
    else $error("cell width and height disagree");
`endif

endmodule
`default_nettype wire
